// ----- src/ptlt_pkg.sv -----
// shared types and constants for the position tagged list table
// no dependencies; imported by ptlt_cell and position_tagged_list_table_core
package ptlt_pkg;

  localparam int SLOTS_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int POS_W          = 11;
  localparam int WORD_W         = 32;
  localparam int CNT_W          = 11;

  // command codes as they arrive on the input beat
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  // operation carried down the cell chain
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [1:0]        status;
    logic [CNT_W-1:0]  count;
  } out_t;

  // control token handed from cell to cell
  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [POS_W-1:0] pos;
    status_e          status;
    logic [CNT_W-1:0] count;
  } tok_t;

endpackage

// ----- src/ptlt_cell.sv -----
// one list cell: holds the word at list position Index and forwards the token
// depends on ptlt_pkg
module ptlt_cell import ptlt_pkg::*; #(
  parameter int Slots     = SLOTS_DEF,
  parameter int DataWidth = DATA_WIDTH_DEF,
  parameter int Index     = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  tok_t                 tok_i,
  input  logic [DataWidth-1:0] carry_i,
  input  logic [DataWidth-1:0] above_word_i,
  output tok_t                 tok_o,
  output logic [DataWidth-1:0] carry_o,
  output logic [DataWidth-1:0] word_o
);

  localparam int CntW = $clog2(Slots + 1);
  localparam int CmpW = (POS_W > CntW) ? POS_W : CntW;

  tok_t                 tok_q;
  logic [DataWidth-1:0] carry_q, carry_d;
  logic [DataWidth-1:0] word_q, word_d;
  logic                 at_or_above;
  logic                 at_pos;

  always_comb begin
    at_or_above = CmpW'(tok_i.pos) <= CmpW'(Index);
    at_pos      = CmpW'(tok_i.pos) == CmpW'(Index);
    word_d      = word_q;
    carry_d     = carry_i;
    if (adv_i && tok_i.valid) begin
      case (tok_i.op)
        OP_INSERT: begin
          // swap carried word with stored word from the insert point upward
          if (at_or_above) begin
            word_d  = carry_i;
            carry_d = word_q;
          end
        end
        OP_REMOVE: begin
          if (at_or_above) begin
            word_d = above_word_i;
          end
        end
        OP_READ: begin
          if (at_pos) begin
            carry_d = word_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (adv_i) begin
      carry_q <= carry_d;
    end
  end

  assign tok_o   = tok_q;
  assign carry_o = carry_q;
  assign word_o  = word_q;

endmodule

// ----- src/position_tagged_list_table_core.sv -----
// top level of the position tagged list table: front stage, cell chain, output register
// depends on ptlt_pkg and ptlt_cell
//
// usage
//   input channel in_valid_i / in_ready_o carries one command beat (insert,
//   remove or read at a list position); output channel out_valid_o /
//   out_ready_i returns exactly one result beat per command, in order
//   the list lives in a chain of Slots cells, cell k holding list element k;
//   a command walks the chain one cell per cycle unless the output stalls;
//   each cell shifts, swaps or samples its word as the command passes
//   status and count are settled when the beat is accepted, from the count
//   register, so refused commands pass down the chain as no-ops
//   a beat passes the front stage, then the Slots cells in order, then the output
//   register; the front stage takes one beat at a time, and as a remove reads the
//   stored word of the cell above, beats keep one empty cell between them in the chain
//   a finished result waits in the output register; while it is not taken
//   the whole chain and the front stage hold, and in_ready_o drops
//   reset empties the list and clears all token valid bits; the cell words
//   need no reset since only elements below the count are ever read
module position_tagged_list_table_core import ptlt_pkg::*; #(
  parameter int Slots     = SLOTS_DEF,
  parameter int DataWidth = DATA_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int CntW = $clog2(Slots + 1);
  localparam int CmpW = (POS_W > CntW) ? POS_W : CntW;

  // chain advance and handshake
  logic adv;
  logic in_fire;

  // list length
  logic [CntW-1:0] count_q, count_d;

  // front stage
  tok_t                 tok_new;
  tok_t                 tok_front_q;
  logic [DataWidth-1:0] carry_front_q;
  logic [DataWidth+WORD_W-1:0] val_ext;

  // chain links
  tok_t                 tok   [Slots+1];
  logic [DataWidth-1:0] carry [Slots+1];
  logic [DataWidth-1:0] word  [Slots+1];

  // output register
  logic                        out_valid_q;
  out_t                        out_q;
  logic [DataWidth+WORD_W-1:0] rd_ext;

  // everything moves unless a finished result is stuck in the output register
  assign adv        = !out_valid_q || out_ready_i;
  // keep one bubble behind each beat
  assign in_ready_o = adv && !tok_front_q.valid;
  assign in_fire    = in_valid_i && in_ready_o;

  // admission: range and full checks against the current count
  always_comb begin
    tok_new        = '0;
    tok_new.valid  = 1'b1;
    tok_new.op     = OP_NONE;
    tok_new.pos    = in_data_i.position;
    tok_new.status = STATUS_OK;
    count_d        = count_q;
    case (in_data_i.command)
      CMD_INSERT: begin
        if (CmpW'(in_data_i.position) > CmpW'(count_q)) begin
          tok_new.status = STATUS_RANGE;
        end else if (count_q == CntW'(Slots)) begin
          tok_new.status = STATUS_FULL;
        end else begin
          tok_new.op = OP_INSERT;
          count_d    = count_q + CntW'(1);
        end
      end
      CMD_REMOVE: begin
        if (CmpW'(in_data_i.position) >= CmpW'(count_q)) begin
          tok_new.status = STATUS_RANGE;
        end else begin
          tok_new.op = OP_REMOVE;
          count_d    = count_q - CntW'(1);
        end
      end
      CMD_READ: begin
        if (CmpW'(in_data_i.position) >= CmpW'(count_q)) begin
          tok_new.status = STATUS_RANGE;
        end else begin
          tok_new.op = OP_READ;
        end
      end
      default: ; // unused command code: no-op, status ok
    endcase
    tok_new.count = CNT_W'(count_d);
  end

  assign val_ext = {{DataWidth{1'b0}}, in_data_i.value};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      tok_front_q <= '0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      if (adv) begin
        tok_front_q <= in_fire ? tok_new : '0;
      end
    end
  end

  // insert value rides in the carry slot
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      carry_front_q <= val_ext[DataWidth-1:0];
    end
  end

  // cell chain
  assign tok[0]     = tok_front_q;
  assign carry[0]   = carry_front_q;
  assign word[Slots] = '0;

  for (genvar k = 0; k < Slots; k++) begin : g_cell
    ptlt_cell #(
      .Slots     (Slots),
      .DataWidth (DataWidth),
      .Index     (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .adv_i        (adv),
      .tok_i        (tok[k]),
      .carry_i      (carry[k]),
      .above_word_i (word[k+1]),
      .tok_o        (tok[k+1]),
      .carry_o      (carry[k+1]),
      .word_o       (word[k])
    );
  end

  // output register: read data only for a successful read
  assign rd_ext = {{WORD_W{1'b0}}, carry[Slots]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tok[Slots].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tok[Slots].valid) begin
      out_q.read_data <= (tok[Slots].op == OP_READ) ? rd_ext[WORD_W-1:0] : '0;
      out_q.status    <= tok[Slots].status;
      out_q.count     <= tok[Slots].count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // list never grows past the slot count
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Slots))
    else $error("list count exceeds slot count");

  // a beat is always followed by an empty cell
  a_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input accepted on back-to-back cycles");

  // a successful insert grows the list by one
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && tok_new.op == OP_INSERT) |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not advance count");

  // chain freezes while the output is stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(tok[Slots]))
    else $error("chain moved during output stall");

endmodule
